// ===== rtl/touch_gesture_classifier_core_assert.svh =====
// Assertion macros for the checker file of the gesture classifier
`ifndef TOUCH_GESTURE_CLASSIFIER_CORE_ASSERT_SVH
`define TOUCH_GESTURE_CLASSIFIER_CORE_ASSERT_SVH

// Check on every clock edge outside reset
`define TGC_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included
`define TGC_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tgc_pkg.sv =====
// Types and constants of the touch gesture classifier
package tgc_pkg;

  localparam int ELECTRODES  = 6;
  localparam int MAX_RESULTS = 6;
  localparam int MASK_W      = 6;
  localparam int TIME_W      = 32;
  localparam int MS_W        = 16;
  localparam int ELEC_W      = 3;
  localparam int KIND_W      = 2;
  localparam int EIDX_W      = (ELECTRODES > 1) ? $clog2(ELECTRODES) : 1;
  localparam int CNT_W       = $clog2(ELECTRODES + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd2;

  localparam logic [MS_W-1:0] LONG_PRESS_RST   = 16'd800;
  localparam logic [MS_W-1:0] DOUBLE_CLICK_RST = 16'd350;

  typedef enum logic [KIND_W-1:0] {
    KIND_TAP    = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_LONG   = 2'd2
  } kind_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } lane_evt_t;

endpackage

// ===== rtl/tgc_if.sv =====
// Request channels of the gesture classifier: polls in, gesture events out
interface tgc_poll_if;
  logic                         valid;
  logic                         ready;
  logic [tgc_pkg::MASK_W-1:0]   touch_mask;
  logic [tgc_pkg::TIME_W-1:0]   now_ms;
  modport source (output valid, touch_mask, now_ms, input ready);
  modport sink   (input valid, touch_mask, now_ms, output ready);
endinterface

interface tgc_gesture_if;
  logic                         valid;
  logic                         ready;
  logic [tgc_pkg::ELEC_W-1:0]   electrode;
  logic [tgc_pkg::KIND_W-1:0]   event_kind;
  logic                         last_event;
  modport source (output valid, electrode, event_kind, last_event, input ready);
  modport sink   (input valid, electrode, event_kind, last_event, output ready);
endinterface

// ===== rtl/touch_gesture_classifier_core.sv =====
// Gesture classifier top level: config registers, electrode lanes and event merge.
// Throughput, set by the merge stage: one event per cycle while gesture.ready is high.
// A poll with several events holds the merge stage until all but the last are sent;
// a poll with one or no event can be accepted every cycle, while gesture.ready is high.
// Reset (rst, synchronous): lane flags and times cleared to zero, enable 0,
// long press 800 ms, double click 350 ms, no event pending.
module touch_gesture_classifier_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tgc_pkg::CFG_DATA_W-1:0]    cfg_data,
  tgc_poll_if.sink                          poll,
  tgc_gesture_if.source                     gesture
);

  logic                             enable;
  logic [tgc_pkg::MS_W-1:0]         long_press_ms;
  logic [tgc_pkg::MS_W-1:0]         double_click_ms;
  logic                             take;
  logic                             step;
  logic [tgc_pkg::ELECTRODES-1:0]   down;
  tgc_pkg::lane_evt_t [tgc_pkg::ELECTRODES-1:0] lane_evt;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b0;
      long_press_ms   <= tgc_pkg::LONG_PRESS_RST;
      double_click_ms <= tgc_pkg::DOUBLE_CLICK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tgc_pkg::CFG_ENABLE:       enable          <= cfg_data[0];
        tgc_pkg::CFG_LONG_PRESS:   long_press_ms   <= cfg_data[tgc_pkg::MS_W-1:0];
        tgc_pkg::CFG_DOUBLE_CLICK: double_click_ms <= cfg_data[tgc_pkg::MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign poll.ready = take;
  // a disabled block still takes the request but leaves every lane untouched
  assign step       = poll.valid && take && enable;

  for (genvar i = 0; i < tgc_pkg::ELECTRODES; i++) begin : g_lane
    if (i < tgc_pkg::MASK_W) begin : g_bit
      assign down[i] = poll.touch_mask[i];
    end else begin : g_none
      assign down[i] = 1'b0;
    end
    tgc_lane u_lane (
      .clk             (clk),
      .rst             (rst),
      .step            (step),
      .down            (down[i]),
      .now_ms          (poll.now_ms),
      .long_press_ms   (long_press_ms),
      .double_click_ms (double_click_ms),
      .evt             (lane_evt[i])
    );
  end

  tgc_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .lane_evt (lane_evt),
    .take     (take),
    .gesture  (gesture)
  );

endmodule

// ===== rtl/tgc_lane.sv =====
// One electrode lane: press state, long-press timer and tap classification
module tgc_lane (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         down,
  input  logic [tgc_pkg::TIME_W-1:0]   now_ms,
  input  logic [tgc_pkg::MS_W-1:0]     long_press_ms,
  input  logic [tgc_pkg::MS_W-1:0]     double_click_ms,
  output tgc_pkg::lane_evt_t           evt
);

  logic                         pressed;
  logic                         long_sent;
  logic [tgc_pkg::TIME_W-1:0]   start_time;
  logic [tgc_pkg::TIME_W-1:0]   tap_time;

  logic                         fresh;
  logic                         eff_long_sent;
  logic [tgc_pkg::TIME_W-1:0]   eff_start;
  logic [tgc_pkg::TIME_W-1:0]   held;
  logic [tgc_pkg::TIME_W-1:0]   since_tap;
  logic                         long_hit;
  logic                         release_hit;
  logic                         is_double;

  always_comb begin
    fresh         = down && !pressed;
    eff_long_sent = fresh ? 1'b0 : long_sent;
    eff_start     = fresh ? now_ms : start_time;
    held          = now_ms - eff_start;
    since_tap     = now_ms - tap_time;
    long_hit      = down && !eff_long_sent &&
                    (held >= {{(tgc_pkg::TIME_W - tgc_pkg::MS_W){1'b0}}, long_press_ms});
    release_hit   = !down && pressed && !long_sent;
    is_double     = since_tap <=
                    {{(tgc_pkg::TIME_W - tgc_pkg::MS_W){1'b0}}, double_click_ms};
    evt.hit       = long_hit || release_hit;
    if (long_hit) begin
      evt.kind = tgc_pkg::KIND_LONG;
    end else if (is_double) begin
      evt.kind = tgc_pkg::KIND_DOUBLE;
    end else begin
      evt.kind = tgc_pkg::KIND_TAP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed    <= 1'b0;
      long_sent  <= 1'b0;
      start_time <= '0;
      tap_time   <= '0;
    end else if (step) begin
      if (down) begin
        pressed    <= 1'b1;
        start_time <= eff_start;
        long_sent  <= eff_long_sent || long_hit;
      end else if (pressed) begin
        pressed <= 1'b0;
        // a double click sets the tap time to zero instead of storing now_ms
        if (release_hit) begin
          tap_time <= is_double ? '0 : now_ms;
        end
      end
    end
  end

endmodule

// ===== rtl/tgc_merge.sv =====
// Merging stage: holds the lane events of one poll and sends them lowest electrode first
module tgc_merge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  step,
  input  tgc_pkg::lane_evt_t [tgc_pkg::ELECTRODES-1:0] lane_evt,
  output logic                                  take,
  tgc_gesture_if.source                         gesture
);

  logic [tgc_pkg::ELECTRODES-1:0]   pend;
  tgc_pkg::kind_t                   pkind [tgc_pkg::ELECTRODES];
  logic                             out_valid;
  logic [tgc_pkg::ELEC_W-1:0]       out_elec;
  tgc_pkg::kind_t                   out_kind;
  logic                             out_last;

  logic                             load;
  logic [tgc_pkg::EIDX_W-1:0]       sel;
  logic [tgc_pkg::ELECTRODES-1:0]   sel_hot;
  logic [tgc_pkg::ELECTRODES-1:0]   rest;
  logic [tgc_pkg::ELECTRODES-1:0]   pend_after;
  logic [tgc_pkg::ELECTRODES-1:0]   new_hits;
  logic [tgc_pkg::CNT_W-1:0]        cnt;

  always_comb begin
    sel     = '0;
    sel_hot = '0;
    for (int i = tgc_pkg::ELECTRODES - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel     = tgc_pkg::EIDX_W'(i);
        sel_hot = tgc_pkg::ELECTRODES'(1) << i;
      end
    end
    load       = !out_valid || gesture.ready;
    rest       = pend & ~sel_hot;
    pend_after = load ? rest : pend;
    take       = (pend_after == '0);
    // keep only the first events of a poll that fit the result limit
    cnt      = '0;
    new_hits = '0;
    for (int i = 0; i < tgc_pkg::ELECTRODES; i++) begin
      if (lane_evt[i].hit && (int'(cnt) < tgc_pkg::MAX_RESULTS)) begin
        new_hits[i] = 1'b1;
        cnt         = cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      pend <= (step && take) ? new_hits : pend_after;
      if (load) begin
        out_valid <= (pend != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_elec <= tgc_pkg::ELEC_W'(sel);
      out_kind <= pkind[sel];
      out_last <= (rest == '0);
    end
    if (step && take) begin
      for (int i = 0; i < tgc_pkg::ELECTRODES; i++) begin
        pkind[i] <= lane_evt[i].kind;
      end
    end
  end

  assign gesture.valid      = out_valid;
  assign gesture.electrode  = out_elec;
  assign gesture.event_kind = out_kind;
  assign gesture.last_event = out_last;

endmodule

// ===== rtl/tgc_checker.sv =====
// Port checker of the gesture classifier and its bind to the top level
`include "touch_gesture_classifier_core_assert.svh"

module tgc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          gesture_valid,
  input logic                          gesture_ready,
  input logic [tgc_pkg::ELEC_W-1:0]    gesture_electrode,
  input logic [tgc_pkg::KIND_W-1:0]    gesture_kind,
  input logic                          gesture_last
);

  `TGC_ASSERT_CLK(a_hold, gesture_valid && !gesture_ready |=> gesture_valid && $stable(gesture_electrode) && $stable(gesture_kind) && $stable(gesture_last), "stalled event changed")
  `TGC_ASSERT_ANY(a_reset, rst |=> !gesture_valid, "event shown after reset")
  `TGC_ASSERT_CLK(a_burst, gesture_valid && gesture_ready && !gesture_last |=> gesture_valid, "gap inside the events of one poll")
  `TGC_ASSERT_CLK(a_order, gesture_valid && gesture_ready && !gesture_last |=> gesture_electrode > $past(gesture_electrode), "events of one poll out of electrode order")

endmodule

bind touch_gesture_classifier_core tgc_checker u_tgc_checker (
  .clk               (clk),
  .rst               (rst),
  .gesture_valid     (gesture.valid),
  .gesture_ready     (gesture.ready),
  .gesture_electrode (gesture.electrode),
  .gesture_kind      (gesture.event_kind),
  .gesture_last      (gesture.last_event)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the touch gesture classifier core
module tb_top;
  import tgc_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  // Timeout guard, set well above the length of the slowest correct run.
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [ELEC_W-1:0] electrode;
    kind_t             kind;
    logic              last;
  } gesture_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_mode_t;

  // Tracks electrode state and the gestures still due from the core.
  class gesture_tracker;
    bit                enabled;
    bit [MS_W-1:0]     hold_ms;
    bit [MS_W-1:0]     window_ms;
    bit                pressed[ELECTRODES];
    bit                long_done[ELECTRODES];
    bit [TIME_W-1:0]   press_at[ELECTRODES];
    bit [TIME_W-1:0]   tapped_at[ELECTRODES];
    gesture_t          due_gestures[$];

    function void clear();
      enabled   = 1'b0;
      hold_ms   = LONG_PRESS_RST;
      window_ms = DOUBLE_CLICK_RST;
      for (int i = 0; i < ELECTRODES; i++) begin
        pressed[i]   = 1'b0;
        long_done[i] = 1'b0;
        press_at[i]  = '0;
        tapped_at[i] = '0;
      end
      due_gestures.delete();
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_ENABLE:       enabled   = val[0];
        CFG_LONG_PRESS:   hold_ms   = val;
        CFG_DOUBLE_CLICK: window_ms = val;
        default: ;
      endcase
    endfunction

    function gesture_t gesture_of(input int idx, input kind_t k);
      gesture_t g;
      g.electrode = ELEC_W'(idx);
      g.kind      = k;
      g.last      = 1'b0;
      return g;
    endfunction

    function void take_poll(input logic [MASK_W-1:0] mask, input logic [TIME_W-1:0] now);
      gesture_t        found[$];
      gesture_t        g;
      bit [TIME_W-1:0] held;
      bit [TIME_W-1:0] since_tap;
      bit              down;
      if (!enabled) return;
      for (int i = 0; i < ELECTRODES; i++) begin
        down = mask[i];
        if (down && !pressed[i]) begin
          pressed[i]   = 1'b1;
          long_done[i] = 1'b0;
          press_at[i]  = now;
        end
        held = now - press_at[i];
        if (down && !long_done[i] && held >= TIME_W'(hold_ms)) begin
          long_done[i] = 1'b1;
          found.push_back(gesture_of(i, KIND_LONG));
        end
        if (!down && pressed[i]) begin
          pressed[i] = 1'b0;
          if (!long_done[i]) begin
            since_tap = now - tapped_at[i];
            if (since_tap <= TIME_W'(window_ms)) begin
              tapped_at[i] = '0;
              found.push_back(gesture_of(i, KIND_DOUBLE));
            end else begin
              tapped_at[i] = now;
              found.push_back(gesture_of(i, KIND_TAP));
            end
          end
        end
      end
      // drop anything beyond the per-poll cap and flag the final one
      for (int n = 0; n < found.size() && n < MAX_RESULTS; n++) begin
        g      = found[n];
        g.last = (n == found.size() - 1) || (n == MAX_RESULTS - 1);
        due_gestures.push_back(g);
      end
    endfunction

    function string match_gesture(input logic [ELEC_W-1:0] elec, input logic [KIND_W-1:0] kind,
                                  input logic last);
      gesture_t want;
      if (due_gestures.size() == 0)
        return $sformatf("unexpected gesture: electrode %0d kind %0d last %0d", elec, kind, last);
      want = due_gestures.pop_front();
      if (want.electrode !== elec || want.kind !== kind || want.last !== last)
        return $sformatf("gesture got electrode %0d kind %0d last %0d, want %0d %0d %0d",
                         elec, kind, last, want.electrode, want.kind, want.last);
      return "";
    endfunction

    function int waiting();
      return due_gestures.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tgc_poll_if    poll_ch();
  tgc_gesture_if gesture_ch();

  touch_gesture_classifier_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .poll      (poll_ch),
    .gesture   (gesture_ch)
  );

  gesture_tracker tracker;
  int             cycle_count = 0;
  int             errors = 0;
  int             polls_taken = 0;
  int             gestures_seen = 0;
  int             taps_seen = 0;
  int             doubles_seen = 0;
  int             longs_seen = 0;
  int             settings_used = 0;
  rx_mode_t       rx_mode = RX_OPEN;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d gestures still due", cycle_count, tracker.waiting());
      $display("FAIL touch_gesture_classifier_core");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Receiver: hold ready low in reset, then switch among four stall patterns picked at random.
  always @(posedge clk) begin
    if (cycle_count % 64 == 0)
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
    if (rst) begin
      gesture_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:    gesture_ch.ready <= 1'b1;
        RX_RANDOM:  gesture_ch.ready <= ($urandom_range(0, 2) != 0);
        RX_SPARSE:  gesture_ch.ready <= (cycle_count[1:0] == 2'd0);
        default:    gesture_ch.ready <= (cycle_count[3:0] >= 4'd10);
      endcase
    end
  end

  always @(posedge clk) begin : gesture_monitor
    string verdict;
    if (!rst && gesture_ch.valid && gesture_ch.ready) begin
      gestures_seen++;
      case (gesture_ch.event_kind)
        KIND_TAP:    taps_seen++;
        KIND_DOUBLE: doubles_seen++;
        KIND_LONG:   longs_seen++;
        default: ;
      endcase
      verdict = tracker.match_gesture(gesture_ch.electrode, gesture_ch.event_kind,
                                      gesture_ch.last_event);
      if (verdict != "")
        report_mismatch(verdict);
    end
  end

  // Called at a clock edge; returns at the edge where the request is taken, valid still high.
  task automatic send_poll(input logic [MASK_W-1:0] mask, input logic [TIME_W-1:0] now);
    poll_ch.valid      <= 1'b1;
    poll_ch.touch_mask <= mask;
    poll_ch.now_ms     <= now;
    do @(posedge clk); while (!poll_ch.ready);
    tracker.take_poll(mask, now);
    polls_taken++;
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold off until every due gesture has arrived, then let the pipeline settle.
  task automatic wait_drain();
    poll_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input bit en, input logic [MS_W-1:0] hold,
                              input logic [MS_W-1:0] window);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENABLE;
    cfg_data  <= CFG_DATA_W'(en);
    tracker.set_reg(CFG_ENABLE, CFG_DATA_W'(en));
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_data  <= hold;
    tracker.set_reg(CFG_LONG_PRESS, hold);
    @(posedge clk);
    cfg_index <= CFG_DOUBLE_CLICK;
    cfg_data  <= window;
    tracker.set_reg(CFG_DOUBLE_CLICK, window);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_directed();
    // disabled after reset: nothing happens
    send_poll(6'h3F, 32'd100);
    send_poll(6'h00, 32'd200);
    program_regs(1'b1, 16'd800, 16'd350);
    // first release close to time zero counts as a double click
    send_poll(6'h01, 32'd10);
    send_poll(6'h00, 32'd100);
    // all six release together: taps, then doubles, then taps again
    send_poll(6'h3F, 32'd1000);
    send_poll(6'h00, 32'd1100);
    send_poll(6'h3F, 32'd1200);
    send_poll(6'h00, 32'd1300);
    send_poll(6'h3F, 32'd1400);
    send_poll(6'h00, 32'd1500);
    // hold one short of the long press, then reach it; the release is silent
    send_poll(6'h3F, 32'd2000);
    send_poll(6'h3F, 32'd2799);
    send_poll(6'h3F, 32'd2800);
    send_poll(6'h00, 32'd2900);
    // zero hold time: long press in the same poll as the touch
    program_regs(1'b1, 16'd0, 16'd0);
    send_poll(6'h2A, 32'd4000);
    send_poll(6'h15, 32'd4000);
    send_poll(6'h00, 32'd4001);
    // widest limits, with the timestamp wrapping mid-press
    program_regs(1'b1, 16'hFFFF, 16'hFFFF);
    send_poll(6'h3F, 32'hFFFF_FF00);
    send_poll(6'h3C, 32'h0000_FEFF);
    send_poll(6'h00, 32'h0001_0000);
    send_poll(6'h03, 32'h8000_0000);
    send_poll(6'h00, 32'h8000_FFFF);
  endtask

  task automatic random_phase(input bit en, input logic [MS_W-1:0] hold,
                              input logic [MS_W-1:0] window, input int polls, input bit steady);
    logic [MASK_W-1:0] mask;
    logic [TIME_W-1:0] now;
    int                burst;
    int                pick;
    program_regs(en, hold, window);
    mask  = '0;
    now   = $urandom();
    burst = $urandom_range(1, 12);
    for (int n = 0; n < polls; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // noise: any mask at any time
        mask = MASK_W'($urandom());
        now  = $urandom();
      end else begin
        if ($urandom_range(0, 3) == 0)
          mask = mask ^ (MASK_W'(1) << $urandom_range(0, ELECTRODES - 1));
        else
          mask = mask ^ MASK_W'($urandom() & $urandom());
        if (pick < 55)
          now = now + $urandom_range(0, int'(window) + int'(window) / 2 + 20);
        else if (pick < 90)
          now = now + $urandom_range(0, int'(hold) + int'(hold) / 4 + 20);
        else
          now = now + $urandom_range(0, 300);
      end
      send_poll(mask, now);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if (!steady)
          pause_sender($urandom_range(0, 5));
      end
    end
  endtask

  initial begin
    tracker = new();
    tracker.clear();
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = CFG_ENABLE;
    cfg_data            = '0;
    poll_ch.valid       = 1'b0;
    poll_ch.touch_mask  = '0;
    poll_ch.now_ms      = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    random_phase(1'b1, 16'd800, 16'd350, 40, 1'b0);
    random_phase(1'b1, 16'd0, 16'd0, 30, 1'b0);
    random_phase(1'b1, 16'hFFFF, 16'hFFFF, 30, 1'b0);
    random_phase(1'b1, MS_W'($urandom_range(20, 600)), MS_W'($urandom_range(20, 600)), 40, 1'b1);
    random_phase(1'b0, 16'd100, 16'd100, 10, 1'b0);
    random_phase(1'b1, 16'hFFFF, 16'd0, 30, 1'b0);
    random_phase(1'b1, 16'd0, 16'hFFFF, 30, 1'b1);
    random_phase(1'b1, MS_W'($urandom_range(1, 2000)), MS_W'($urandom_range(1, 1000)), 50, 1'b0);

    wait_drain();
    $display("run covered %0d polls over %0d register settings, %0d gestures checked",
             polls_taken, settings_used, gestures_seen);
    $display("gestures seen: %0d taps, %0d double clicks, %0d long presses, %0d mismatches",
             taps_seen, doubles_seen, longs_seen, errors);
    if (errors == 0)
      $display("PASS touch_gesture_classifier_core");
    else
      $display("FAIL touch_gesture_classifier_core");
    $finish;
  end

endmodule
